FILE: rtl/core/cfla_pkg.sv
// Shared types, sizes and status codes of the chunked free list allocator.
// Every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cfla_pkg;

  // Pool geometry
  localparam int SLOT_W       = 8;
  localparam int CHUNK_ITEMS  = 1 << SLOT_W;
  localparam int MAX_CHUNKS   = 64;
  localparam int CHUNK_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int COUNT_W      = SLOT_W + 1;
  localparam int STACK_ADDR_W = CHUNK_W + SLOT_W;

  // Field widths
  localparam int HANDLE_W    = 14;
  localparam int ROW_W       = HANDLE_W - SLOT_W;
  localparam int ITEM_SIZE_W = 13;
  localparam int OFFSET_W    = 26;
  localparam int STATUS_W    = 2;
  localparam int CCOUNT_W    = 7;

  localparam logic [ITEM_SIZE_W-1:0] ITEM_SIZE_RESET = ITEM_SIZE_W'(64);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = STATUS_W'(2);

  typedef struct packed {
    logic                mode;
    logic [HANDLE_W-1:0] free_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [OFFSET_W-1:0] byte_offset;
    logic [STATUS_W-1:0] status;
    logic [CCOUNT_W-1:0] chunks_in_use;
  } rsp_t;

  // Write into the chunk count table
  typedef struct packed {
    logic               en;
    logic [CHUNK_W-1:0] chunk;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] low;
  } tbl_wr_t;

  // Lowest chunk with a free item and lowest chunk with room
  typedef struct packed {
    logic               pop_found;
    logic [CHUNK_W-1:0] pop_chunk;
    logic               push_found;
    logic [CHUNK_W-1:0] push_chunk;
  } find_t;

  // Single-bit write into the allocated map
  typedef struct packed {
    logic               en;
    logic [CHUNK_W-1:0] row;
    logic [SLOT_W-1:0]  slot;
    logic               value;
  } map_wr_t;

endpackage

`default_nettype wire

FILE: rtl/core/cfla_chunk_table.sv
// Per-chunk fill count and low-water mark table, plus the empty/full bitmaps
// and the lowest-chunk search. Depends on cfla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfla_chunk_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [cfla_pkg::CHUNK_W-1:0] rd_chunk,
  output logic      [cfla_pkg::COUNT_W-1:0] rd_count,
  output logic      [cfla_pkg::COUNT_W-1:0] rd_low,
  input  wire cfla_pkg::tbl_wr_t           wr,
  output cfla_pkg::find_t                  find
);

  localparam logic [cfla_pkg::COUNT_W-1:0] FULL =
    cfla_pkg::COUNT_W'(cfla_pkg::CHUNK_ITEMS);

  logic [2*cfla_pkg::COUNT_W-1:0] mem [cfla_pkg::MAX_CHUNKS];
  logic [2*cfla_pkg::COUNT_W-1:0] ent_q;
  logic [cfla_pkg::MAX_CHUNKS-1:0] valid;
  logic                            valid_q;
  logic [cfla_pkg::MAX_CHUNKS-1:0] nonempty;
  logic [cfla_pkg::MAX_CHUNKS-1:0] notfull;

  // Read and write the count memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ent_q <= mem[rd_chunk];
    end
    if (wr.en) begin
      mem[wr.chunk] <= {wr.count, wr.low};
    end
  end

  // Track written entries and the empty/full state of each created chunk
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      valid_q  <= 1'b0;
      nonempty <= cfla_pkg::MAX_CHUNKS'(1);
      notfull  <= '0;
    end else begin
      if (rd_en) begin
        valid_q <= valid[rd_chunk];
      end
      if (wr.en) begin
        valid[wr.chunk]    <= 1'b1;
        nonempty[wr.chunk] <= (wr.count != '0);
        notfull[wr.chunk]  <= (wr.count != FULL);
      end
    end
  end

  // An entry never written belongs to a full, untouched chunk
  assign rd_count = valid_q ? ent_q[2*cfla_pkg::COUNT_W-1:cfla_pkg::COUNT_W] : FULL;
  assign rd_low   = valid_q ? ent_q[cfla_pkg::COUNT_W-1:0] : FULL;

  // Find the lowest chunk with an item and the lowest with room
  always_comb begin
    find = '0;
    for (int i = cfla_pkg::MAX_CHUNKS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        find.pop_found = 1'b1;
        find.pop_chunk = cfla_pkg::CHUNK_W'(i);
      end
      if (notfull[i]) begin
        find.push_found = 1'b1;
        find.push_chunk = cfla_pkg::CHUNK_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cfla_alloc_map.sv
// Allocated-handle bitmap, one memory row per chunk with a row valid bit.
// A bit write modifies the row fetched by the previous read. Depends on cfla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfla_alloc_map (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        rd_en,
  input  wire logic [cfla_pkg::CHUNK_W-1:0] rd_row,
  input  wire logic [cfla_pkg::SLOT_W-1:0]  slot,
  output logic                             bit_q,
  input  wire cfla_pkg::map_wr_t           wr
);

  logic [cfla_pkg::CHUNK_ITEMS-1:0] mem [cfla_pkg::MAX_CHUNKS];
  logic [cfla_pkg::CHUNK_ITEMS-1:0] row_q;
  logic [cfla_pkg::CHUNK_ITEMS-1:0] row_base;
  logic [cfla_pkg::CHUNK_ITEMS-1:0] row_new;
  logic [cfla_pkg::MAX_CHUNKS-1:0]  row_valid;
  logic                             row_valid_q;

  // Unwritten rows read as all clear
  assign row_base = row_valid_q ? row_q : '0;
  assign bit_q    = row_base[slot];

  // Patch one bit of the fetched row
  always_comb begin
    row_new           = row_base;
    row_new[wr.slot]  = wr.value;
  end

  // Read and write the row memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_q <= mem[rd_row];
    end
    if (wr.en) begin
      mem[wr.row] <= row_new;
    end
  end

  // Mark rows written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      row_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        row_valid_q <= row_valid[rd_row];
      end
      if (wr.en) begin
        row_valid[wr.row] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/chunked_free_list_allocator.sv
// Top level of the chunked free list allocator: request sequencer and stack memory.
// Depends on cfla_pkg, cfla_chunk_table and cfla_alloc_map.
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size block pool of up to 64 chunks of 256 items. One request is taken at a
// time and gives one result. An allocate passes through the states POP, STK and SET
// before OUT, a free through FREE, and an allocate that finds the pool exhausted goes
// straight to OUT. An allocate reads in turn the chunk count table, the free stack
// memory and the allocated map row; the count table and the map row are written
// back. A new request is accepted while the previous result still waits in the
// output register. There is no clearing pass after reset: count table entries and
// map rows carry valid bits, and each chunk keeps a low-water mark below which its
// stack slots still hold the chunk's own handles.
module chunked_free_list_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [cfla_pkg::ITEM_SIZE_W-1:0] cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire cfla_pkg::req_t                  req_data,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output cfla_pkg::rsp_t                       rsp_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_STK  = 3'd2;
  localparam logic [2:0] S_SET  = 3'd3;
  localparam logic [2:0] S_FREE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [cfla_pkg::CCOUNT_W-1:0] CHUNK_LIMIT =
    cfla_pkg::CCOUNT_W'(cfla_pkg::MAX_CHUNKS);

  // Control registers
  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic [cfla_pkg::ITEM_SIZE_W-1:0]  unit_bytes;
  logic [cfla_pkg::CCOUNT_W-1:0]     chunk_count;

  // Request context
  logic [cfla_pkg::CHUNK_W-1:0]      cur_chunk;
  logic                              in_range;
  logic                              push_found;
  logic                              use_default;
  logic [cfla_pkg::SLOT_W-1:0]       top_q;
  logic [cfla_pkg::HANDLE_W-1:0]     res_handle;
  logic [cfla_pkg::STATUS_W-1:0]     res_status;

  // Stack memory
  logic [cfla_pkg::HANDLE_W-1:0]     stack_mem [1 << cfla_pkg::STACK_ADDR_W];
  logic [cfla_pkg::HANDLE_W-1:0]     stack_q;
  logic                              stk_rd_en;
  logic                              stk_wr_en;
  logic [cfla_pkg::STACK_ADDR_W-1:0] stk_rd_addr;
  logic [cfla_pkg::STACK_ADDR_W-1:0] stk_wr_addr;

  // Submodule interfaces
  logic                              accept;
  logic                              tbl_rd_en;
  logic [cfla_pkg::CHUNK_W-1:0]      tbl_rd_chunk;
  logic [cfla_pkg::COUNT_W-1:0]      rd_count;
  logic [cfla_pkg::COUNT_W-1:0]      rd_low;
  cfla_pkg::tbl_wr_t                 tbl_wr;
  cfla_pkg::find_t                   find;
  logic                              map_rd_en;
  logic [cfla_pkg::CHUNK_W-1:0]      map_rd_row;
  logic                              map_bit;
  cfla_pkg::map_wr_t                 map_wr;

  logic [cfla_pkg::ROW_W-1:0]        req_row;
  logic                              new_chunk_ok;
  logic [cfla_pkg::COUNT_W-1:0]      top;
  logic                              below_low;
  logic [cfla_pkg::HANDLE_W-1:0]     pop_handle;
  logic                              free_ok;
  logic                              rsp_load;
  logic [cfla_pkg::OFFSET_W:0]       product;

  assign req_stall    = (state != S_IDLE);
  assign accept       = req_valid && (state == S_IDLE);
  assign req_row      = req_data.free_handle[cfla_pkg::HANDLE_W-1:cfla_pkg::SLOT_W];
  assign new_chunk_ok = (chunk_count < CHUNK_LIMIT);
  assign top          = rd_count - cfla_pkg::COUNT_W'(1);
  assign below_low    = (top < rd_low);
  assign pop_handle   = use_default
                        ? cfla_pkg::HANDLE_W'({cur_chunk, top_q})
                        : stack_q;
  assign free_ok      = in_range && map_bit && push_found;
  assign rsp_load     = (state == S_OUT) && (!rsp_valid || !rsp_stall);
  assign product      = (cfla_pkg::OFFSET_W + 1)'(res_handle)
                        * (cfla_pkg::OFFSET_W + 1)'(unit_bytes);

  // Pick the chunk whose count to fetch
  always_comb begin
    tbl_rd_en = accept;
    if (req_data.mode) begin
      tbl_rd_chunk = find.push_chunk;
    end else if (find.pop_found) begin
      tbl_rd_chunk = find.pop_chunk;
    end else begin
      tbl_rd_chunk = chunk_count[cfla_pkg::CHUNK_W-1:0];
    end
  end

  // Update the count table after a pop or a push
  always_comb begin
    tbl_wr = '0;
    if (state == S_POP) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.chunk = cur_chunk;
      tbl_wr.count = top;
      tbl_wr.low   = below_low ? top : rd_low;
    end else if (state == S_FREE && free_ok) begin
      tbl_wr.en    = 1'b1;
      tbl_wr.chunk = cur_chunk;
      tbl_wr.count = rd_count + cfla_pkg::COUNT_W'(1);
      tbl_wr.low   = rd_low;
    end
  end

  // Fetch the map row of the freed or the popped handle
  always_comb begin
    map_rd_en  = (accept && req_data.mode) || (state == S_STK);
    map_rd_row = (state == S_STK)
                 ? cfla_pkg::CHUNK_W'(pop_handle[cfla_pkg::HANDLE_W-1:cfla_pkg::SLOT_W])
                 : cfla_pkg::CHUNK_W'(req_row);
  end

  // Set the bit on allocate, clear it on free
  always_comb begin
    map_wr      = '0;
    map_wr.row  = cfla_pkg::CHUNK_W'(res_handle[cfla_pkg::HANDLE_W-1:cfla_pkg::SLOT_W]);
    map_wr.slot = res_handle[cfla_pkg::SLOT_W-1:0];
    if (state == S_SET) begin
      map_wr.en    = 1'b1;
      map_wr.value = 1'b1;
    end else if (state == S_FREE && free_ok) begin
      map_wr.en    = 1'b1;
      map_wr.value = 1'b0;
    end
  end

  // Stack accesses: pop reads the top slot, push writes above it
  assign stk_rd_en   = (state == S_POP);
  assign stk_rd_addr = {cur_chunk, top[cfla_pkg::SLOT_W-1:0]};
  assign stk_wr_en   = (state == S_FREE) && free_ok;
  assign stk_wr_addr = {cur_chunk, rd_count[cfla_pkg::SLOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (stk_rd_en) begin
      stack_q <= stack_mem[stk_rd_addr];
    end
    if (stk_wr_en) begin
      stack_mem[stk_wr_addr] <= res_handle;
    end
  end

  // Sequence one request
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_data.mode) begin
            state_next = S_FREE;
          end else if (find.pop_found || new_chunk_ok) begin
            state_next = S_POP;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_POP:  state_next = S_STK;
      S_STK:  state_next = S_SET;
      S_SET:  state_next = S_OUT;
      S_FREE: state_next = S_OUT;
      S_OUT: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold control state, chunk count, item size and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      unit_bytes  <= cfla_pkg::ITEM_SIZE_RESET;
      chunk_count <= cfla_pkg::CCOUNT_W'(1);
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unit_bytes <= cfg_data;
      end
      if (accept && !req_data.mode && !find.pop_found && new_chunk_ok) begin
        chunk_count <= chunk_count + cfla_pkg::CCOUNT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture request context and the result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_chunk  <= tbl_rd_chunk;
          in_range   <= (cfla_pkg::CCOUNT_W'(req_row) < chunk_count);
          push_found <= find.push_found;
          if (req_data.mode) begin
            res_handle <= req_data.free_handle;
          end else begin
            res_handle <= '0;
            res_status <= cfla_pkg::ST_NO_ROOM;
          end
        end
      end
      S_POP: begin
        top_q       <= top[cfla_pkg::SLOT_W-1:0];
        use_default <= below_low;
      end
      S_STK: begin
        res_handle <= pop_handle;
      end
      S_SET: begin
        res_status <= cfla_pkg::ST_OK;
      end
      S_FREE: begin
        if (!in_range || !map_bit) begin
          res_status <= cfla_pkg::ST_NOT_ALLOC;
        end else if (!push_found) begin
          res_status <= cfla_pkg::ST_NO_ROOM;
        end else begin
          res_status <= cfla_pkg::ST_OK;
        end
      end
      S_OUT: begin
        if (rsp_load) begin
          rsp_data.handle        <= res_handle;
          rsp_data.byte_offset   <= product[cfla_pkg::OFFSET_W-1:0];
          rsp_data.status        <= res_status;
          rsp_data.chunks_in_use <= chunk_count;
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  cfla_chunk_table u_chunk_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (tbl_rd_en),
    .rd_chunk (tbl_rd_chunk),
    .rd_count (rd_count),
    .rd_low   (rd_low),
    .wr       (tbl_wr),
    .find     (find)
  );

  cfla_alloc_map u_alloc_map (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (map_rd_en),
    .rd_row (map_rd_row),
    .slot   (res_handle[cfla_pkg::SLOT_W-1:0]),
    .bit_q  (map_bit),
    .wr     (map_wr)
  );

endmodule

`default_nettype wire
